>>> sv/rle_bitblt_pixel_decoder_core_defines.svh
// Assertion macros for the RLE bitblt pixel decoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef RLE_BITBLT_PIXEL_DECODER_CORE_DEFINES_SVH
`define RLE_BITBLT_PIXEL_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define RBPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbpd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RBPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbpd check failed");

`else

`define RBPD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RBPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/rbpd_pkg.sv
// Shared types and constants of the RLE bitblt pixel decoder.
// No dependencies; imported by rle_bitblt_pixel_decoder_core.
`timescale 1ns / 1ps
`default_nettype none

package rbpd_pkg;

    // Field widths fixed by the interface
    localparam int POS_BITS        = 12;
    localparam int LINE_BITS       = 14;
    localparam int FRAME_BITS      = 24;
    localparam int WRITE_ADDR_BITS = 24;
    localparam int BYTE_BITS       = 8;
    localparam int PIXEL_BITS      = 16;
    localparam int COUNT_BITS      = 8;
    localparam int CFG_DATA_BITS   = 24;
    localparam int CFG_INDEX_BITS  = 1;

    // Begin address: x*2 + y*pitch
    localparam int PROD_BITS      = POS_BITS + LINE_BITS;
    localparam int BEGIN_SUM_BITS = PROD_BITS + 1;

    // Register reset values
    localparam logic [LINE_BITS-1:0]  LINE_BYTES_RESET  = 14'd1600;
    localparam logic [FRAME_BITS-1:0] FRAME_BYTES_RESET = 24'd768000;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_BYTES  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_BYTES = 1'b1;

    // Request kinds
    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_HEAD     = 5'b00001,
        PH_PIX_HIGH = 5'b00010,
        PH_RUN_LOW  = 5'b00100,
        PH_RUN_HIGH = 5'b01000,
        PH_LIT_LOW  = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

>>> sv/rle_bitblt_pixel_decoder_core.sv
// RLE / raw 16bpp bitblt payload decoder producing framebuffer pixel writes.
// Depends on rbpd_pkg and rle_bitblt_pixel_decoder_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "rle_bitblt_pixel_decoder_core_defines.svh"

// Usage
// - Input channel (in_valid / in_stall): one request per accepted edge, either a
//   begin (action 0: pos_x, pos_y, rle_mode) or one payload byte (action 1).
// - Output channel (out_valid / out_stall): one pixel write request, or a
//   zero-count end marker when the last byte completes no pixel.
// - Config port: cfg_wr_en / cfg_index / cfg_data, write only, change only
//   while the block is idle.
// - Path: an accepted request is registered in the input register, then
//   decoded into the result register, which drives out_valid and the
//   write fields.
// - Throughput: 1 request per cycle unless a held result stalls the input,
//   set by the single decode stage that updates parser state and address.
// - Stall: the result register holds while out_stall is high; one further
//   request can sit in the input register. Requests that give no result
//   (begin, header byte, low byte) still drain past a stalled output.
// - Reset: parser awaits a header in raw mode, address 0, pitch 1600,
//   frame size 768000, both channels empty.

module rle_bitblt_pixel_decoder_core
    import rbpd_pkg::*;
#(
    parameter int ADDR_BITS = 24
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    // config write port
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,

    // input channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      action,
    input  wire logic [POS_BITS-1:0]       pos_x,
    input  wire logic [POS_BITS-1:0]       pos_y,
    input  wire logic                      rle_mode,
    input  wire logic [BYTE_BITS-1:0]      data_byte,
    input  wire logic                      last_byte,

    // output channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [WRITE_ADDR_BITS-1:0]     write_addr,
    output logic [PIXEL_BITS-1:0]          pixel_value,
    output logic [COUNT_BITS-1:0]          repeat_count,
    output logic                           out_of_range,
    output logic                           end_of_blit
);

    // End address needs a carry bit; compares run at the wider of it and frame size.
    localparam int END_BITS   = ADDR_BITS + 1;
    localparam int CMP_BITS   = (END_BITS > FRAME_BITS) ? END_BITS : FRAME_BITS;
    localparam int BWIDE_BITS = (ADDR_BITS > BEGIN_SUM_BITS) ? ADDR_BITS : BEGIN_SUM_BITS;
    localparam int WADDR_BITS = (ADDR_BITS > WRITE_ADDR_BITS) ? ADDR_BITS : WRITE_ADDR_BITS;
    localparam int MAX_RUN    = 128;

    // ---------------- configuration ----------------
    logic [LINE_BITS-1:0]  line_bytes_reg;
    logic [FRAME_BITS-1:0] frame_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg  <= LINE_BYTES_RESET;
            frame_bytes_reg <= FRAME_BYTES_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LINE_BYTES:  line_bytes_reg  <= cfg_data[LINE_BITS-1:0];
                CFG_FRAME_BYTES: frame_bytes_reg <= cfg_data[FRAME_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_action_reg;
    logic [POS_BITS-1:0]  s1_pos_x_reg;
    logic [POS_BITS-1:0]  s1_pos_y_reg;
    logic                 s1_rle_mode_reg;
    logic [BYTE_BITS-1:0] s1_byte_reg;
    logic                 s1_last_reg;
    logic                 out_valid_reg;

    logic in_accept;
    logic s1_produce;   // request in s1 yields a result
    logic s1_adv;       // s1 may move on this cycle
    logic s1_proc;      // s1 is decoded this cycle

    assign s1_adv    = !out_valid_reg || !out_stall || !s1_produce;
    assign s1_proc   = s1_valid_reg && s1_adv;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg   <= action;
            s1_pos_x_reg    <= pos_x;
            s1_pos_y_reg    <= pos_y;
            s1_rle_mode_reg <= rle_mode;
            s1_byte_reg     <= data_byte;
            s1_last_reg     <= last_byte;
        end
    end

    // ---------------- parser state ----------------
    logic [ADDR_BITS-1:0]  next_addr_reg;
    logic [ADDR_BITS-1:0]  next_addr_next;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [COUNT_BITS-1:0] left_reg;
    logic [COUNT_BITS-1:0] left_next;
    logic [BYTE_BITS-1:0]  hold_reg;
    logic [BYTE_BITS-1:0]  hold_next;
    logic                  coded_reg;
    logic                  coded_next;

    // begin address: one 12x14 multiply and one add
    logic [PROD_BITS-1:0]      begin_prod;
    logic [BEGIN_SUM_BITS-1:0] begin_sum;
    logic [BWIDE_BITS-1:0]     begin_wide;

    assign begin_prod = s1_pos_y_reg * line_bytes_reg;
    assign begin_sum  = BEGIN_SUM_BITS'(begin_prod) + BEGIN_SUM_BITS'({s1_pos_x_reg, 1'b0});
    assign begin_wide = BWIDE_BITS'(begin_sum);

    // payload decode
    logic                  emit;
    logic [COUNT_BITS-1:0] emit_count;
    logic [PIXEL_BITS-1:0] emit_pixel;
    logic [END_BITS-1:0]   end_sum;
    logic                  past_frame;

    always_comb
    begin
        emit       = 1'b0;
        emit_count = '0;
        emit_pixel = {s1_byte_reg, hold_reg};
        phase_next = phase_reg;
        left_next  = left_reg;
        hold_next  = hold_reg;
        case (phase_reg)
            PH_PIX_HIGH:
            begin
                emit       = 1'b1;
                emit_count = COUNT_BITS'(1);
                if (coded_reg && (left_reg > COUNT_BITS'(1)))
                begin
                    left_next  = left_reg - COUNT_BITS'(1);
                    phase_next = PH_LIT_LOW;
                end
                else
                begin
                    left_next  = '0;
                    phase_next = PH_HEAD;
                end
            end
            PH_RUN_LOW:
            begin
                hold_next  = s1_byte_reg;
                phase_next = PH_RUN_HIGH;
            end
            PH_RUN_HIGH:
            begin
                emit       = 1'b1;
                emit_count = left_reg;
                left_next  = '0;
                phase_next = PH_HEAD;
            end
            PH_LIT_LOW:
            begin
                hold_next  = s1_byte_reg;
                phase_next = PH_PIX_HIGH;
            end
            default:
            begin
                // section header, or low byte in raw mode
                if (!coded_reg)
                begin
                    hold_next  = s1_byte_reg;
                    phase_next = PH_PIX_HIGH;
                end
                else
                begin
                    left_next  = COUNT_BITS'(s1_byte_reg[BYTE_BITS-2:0]) + COUNT_BITS'(1);
                    phase_next = s1_byte_reg[BYTE_BITS-1] ? PH_RUN_LOW : PH_LIT_LOW;
                end
            end
        endcase

        // last byte: close out, marker result if no pixel was completed
        if (s1_last_reg)
        begin
            if (!emit)
            begin
                emit_pixel = '0;
                emit_count = '0;
            end
            phase_next = PH_HEAD;
            left_next  = '0;
            hold_next  = '0;
        end
    end

    assign end_sum    = END_BITS'(next_addr_reg) + END_BITS'({emit_count, 1'b0});
    assign past_frame = (emit_count != '0) &&
                        (CMP_BITS'(end_sum) > CMP_BITS'(frame_bytes_reg));
    assign s1_produce = (s1_action_reg == ACT_DATA) && (emit || s1_last_reg);

    // state update; a begin overrides the payload decode
    logic [ADDR_BITS-1:0]  st_addr;
    phase_t                st_phase;
    logic [COUNT_BITS-1:0] st_left;
    logic [BYTE_BITS-1:0]  st_hold;

    always_comb
    begin
        next_addr_next = next_addr_reg;
        st_phase = phase_reg;
        st_addr  = next_addr_reg;
        st_left  = left_reg;
        st_hold  = hold_reg;
        coded_next = coded_reg;
        if (s1_proc)
        begin
            if (s1_action_reg == ACT_BEGIN)
            begin
                st_addr    = begin_wide[ADDR_BITS-1:0];
                st_phase   = PH_HEAD;
                st_left    = '0;
                st_hold    = '0;
                coded_next = s1_rle_mode_reg;
            end
            else
            begin
                st_addr  = end_sum[ADDR_BITS-1:0];
                st_phase = phase_next;
                st_left  = left_next;
                st_hold  = hold_next;
            end
        end
        next_addr_next = st_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_addr_reg <= '0;
            phase_reg     <= PH_HEAD;
            left_reg      <= '0;
            hold_reg      <= '0;
            coded_reg     <= 1'b0;
        end
        else
        begin
            next_addr_reg <= next_addr_next;
            phase_reg     <= st_phase;
            left_reg      <= st_left;
            hold_reg      <= st_hold;
            coded_reg     <= coded_next;
        end
    end

    // ---------------- result register ----------------
    logic                       out_valid_next;
    logic [WRITE_ADDR_BITS-1:0] out_addr_reg;
    logic [PIXEL_BITS-1:0]      out_pixel_reg;
    logic [COUNT_BITS-1:0]      out_count_reg;
    logic                       out_oor_reg;
    logic                       out_eob_reg;
    logic [WADDR_BITS-1:0]      addr_ext;
    logic                       out_load;

    assign addr_ext = WADDR_BITS'(next_addr_reg);
    assign out_load = s1_proc && s1_produce;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_addr_reg  <= addr_ext[WRITE_ADDR_BITS-1:0];
            out_pixel_reg <= emit_pixel;
            out_count_reg <= emit_count;
            out_oor_reg   <= past_frame;
            out_eob_reg   <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_addr   = out_addr_reg;
    assign pixel_value  = out_pixel_reg;
    assign repeat_count = out_count_reg;
    assign out_of_range = out_oor_reg;
    assign end_of_blit  = out_eob_reg;

    // ---------------- checks ----------------
    `RBPD_ASSERT_NOW(a_run_in_range, clk, rst_n, out_valid, repeat_count <= COUNT_BITS'(MAX_RUN))
    `RBPD_ASSERT_NOW(a_oor_has_pixels, clk, rst_n, out_valid && out_of_range, repeat_count != '0)
    `RBPD_ASSERT_NOW(a_empty_only_at_end, clk, rst_n, out_valid && (repeat_count == '0), end_of_blit)
    `RBPD_ASSERT_NOW(a_coded_phase_count, clk, rst_n,
        (phase_reg == PH_RUN_LOW) || (phase_reg == PH_RUN_HIGH) || (phase_reg == PH_LIT_LOW),
        left_reg != '0)
    `RBPD_ASSERT_NEXT(a_begin_sets_head, clk, rst_n, s1_proc && (s1_action_reg == ACT_BEGIN),
        phase_reg == PH_HEAD)

endmodule

`default_nettype wire

>>> tb/tb_rle_bitblt_pixel_decoder_core.sv
// Self-checking testbench for rle_bitblt_pixel_decoder_core: a directed table, then random
// blits under several register settings, idling patterns and one long output hold-off.
// Depends on rbpd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_rle_bitblt_pixel_decoder_core;
    import rbpd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;  // generous watchdog limit on the whole run
    localparam int PHASE_ITEMS = 80;      // random requests per phase
    localparam int DRAIN_WAIT  = 8;       // lets the pipeline empty, with margin
    localparam int HOLD_LEN    = 300;     // long output hold-off, in cycles
    localparam int DIR_ROWS    = 26;

    // One input request, as presented on the input channel
    typedef struct packed {
        logic                  act;
        logic [POS_BITS-1:0]   x;
        logic [POS_BITS-1:0]   y;
        logic                  mode;
        logic [BYTE_BITS-1:0]  data;
        logic                  last;
    } req_t;

    // One framebuffer write request, as seen on the output channel
    typedef struct packed {
        logic [WRITE_ADDR_BITS-1:0] addr;
        logic [PIXEL_BITS-1:0]      pix;
        logic [COUNT_BITS-1:0]      cnt;
        logic                       oor;
        logic                       eob;
    } pix_write_t;

    // Directed row: the request, and a hand-typed write where one is obvious
    typedef struct packed {
        req_t       req;
        logic       typed;
        pix_write_t want;
    } dir_row_t;

    localparam pix_write_t NO_WRITE = '0;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = CFG_LINE_BYTES;
    logic [CFG_DATA_BITS-1:0]   cfg_data  = '0;

    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic                       action    = ACT_BEGIN;
    logic [POS_BITS-1:0]        pos_x     = '0;
    logic [POS_BITS-1:0]        pos_y     = '0;
    logic                       rle_mode  = 1'b0;
    logic [BYTE_BITS-1:0]       data_byte = '0;
    logic                       last_byte = 1'b0;

    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [WRITE_ADDR_BITS-1:0] write_addr;
    logic [PIXEL_BITS-1:0]      pixel_value;
    logic [COUNT_BITS-1:0]      repeat_count;
    logic                       out_of_range;
    logic                       end_of_blit;

    always #2 clk = ~clk;

    rle_bitblt_pixel_decoder_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .rle_mode     (rle_mode),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_addr   (write_addr),
        .pixel_value  (pixel_value),
        .repeat_count (repeat_count),
        .out_of_range (out_of_range),
        .end_of_blit  (end_of_blit)
    );

    // ------------------------------------------------------------------
    // Decoder prediction: own copy of registers and parser state
    // ------------------------------------------------------------------
    logic [LINE_BITS-1:0]       pitch_bytes = LINE_BYTES_RESET;
    logic [FRAME_BITS-1:0]      fb_bytes    = FRAME_BYTES_RESET;
    logic [WRITE_ADDR_BITS-1:0] pred_addr   = '0;
    phase_t                     pred_phase  = PH_HEAD;
    logic [COUNT_BITS-1:0]      pred_left   = '0;
    logic [BYTE_BITS-1:0]       pred_low    = '0;
    logic                       pred_coded  = 1'b0;

    pix_write_t pending_writes[$];   // writes predicted, not yet seen
    pix_write_t oldest_write;
    int         fault_count = 0;
    int         cycle_count = 0;

    // Knobs shared with the receiver
    int         idle_pct  = 0;
    int         stall_pct = 0;
    logic       hold_tog  = 1'b0;
    logic       hold_seen = 1'b0;
    int         hold_left = 0;

    // A write of cnt pixels at the running address; bounds check is on the
    // unwrapped end, the address itself wraps at 24 bits.
    function automatic pix_write_t make_write(input logic [PIXEL_BITS-1:0] pix,
                                              input logic [COUNT_BITS-1:0] cnt,
                                              input logic eob);
        pix_write_t w;
        logic [WRITE_ADDR_BITS:0] span_end;
        span_end = {1'b0, pred_addr} + {16'd0, cnt, 1'b0};
        w.addr   = pred_addr;
        w.pix    = pix;
        w.cnt    = cnt;
        w.oor    = (cnt != '0) && (span_end > {1'b0, fb_bytes});
        w.eob    = eob;
        pred_addr = span_end[WRITE_ADDR_BITS-1:0];
        return w;
    endfunction

    // Advances the parser by one request; returns 1 when a write results
    function automatic bit decode_request(input req_t r, output pix_write_t w);
        bit          produced;
        logic [31:0] start;
        produced = 1'b0;
        w        = NO_WRITE;
        if (r.act == ACT_BEGIN)
        begin
            start       = 32'(r.x) * 32'd2 + 32'(r.y) * 32'(pitch_bytes);
            pred_addr   = start[WRITE_ADDR_BITS-1:0];
            pred_coded  = r.mode;
            pred_phase  = PH_HEAD;
            pred_left   = '0;
            pred_low    = '0;
            return 1'b0;
        end
        case (pred_phase)
            PH_PIX_HIGH:
            begin
                w = make_write({r.data, pred_low}, 8'd1, r.last);
                produced = 1'b1;
                if (pred_coded && pred_left > 8'd1)
                begin
                    pred_left  = pred_left - 8'd1;
                    pred_phase = PH_LIT_LOW;
                end
                else
                begin
                    pred_left  = '0;
                    pred_phase = PH_HEAD;
                end
            end
            PH_RUN_LOW:
            begin
                pred_low   = r.data;
                pred_phase = PH_RUN_HIGH;
            end
            PH_RUN_HIGH:
            begin
                w = make_write({r.data, pred_low}, pred_left, r.last);
                produced   = 1'b1;
                pred_left  = '0;
                pred_phase = PH_HEAD;
            end
            PH_LIT_LOW:
            begin
                pred_low   = r.data;
                pred_phase = PH_PIX_HIGH;
            end
            default:
            begin
                if (!pred_coded)
                begin
                    pred_low   = r.data;
                    pred_phase = PH_PIX_HIGH;
                end
                else
                begin
                    pred_left  = {1'b0, r.data[6:0]} + 8'd1;
                    pred_phase = r.data[7] ? PH_RUN_LOW : PH_LIT_LOW;
                end
            end
        endcase
        if (r.last)
        begin
            // last byte that completes no pixel still closes the blit with a marker
            if (!produced)
            begin
                w        = NO_WRITE;
                w.addr   = pred_addr;
                w.eob    = 1'b1;
                produced = 1'b1;
            end
            pred_phase = PH_HEAD;
            pred_left  = '0;
            pred_low   = '0;
        end
        return produced;
    endfunction

    // ------------------------------------------------------------------
    // Directed table; typed writes only where they can be read off directly
    // ------------------------------------------------------------------
    dir_row_t dir_rows [DIR_ROWS] = '{
        // payload before any begin: raw from address 0
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'hFF, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h00, 1'b0}, 1'b1,
          '{24'd0, 16'h00FF, 8'd1, 1'b0, 1'b0}},
        // last on a lone low byte: zero-count end marker
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'hAB, 1'b1}, 1'b1,
          '{24'd2, 16'h0000, 8'd0, 1'b0, 1'b1}},
        // extreme position, far beyond the frame
        '{'{ACT_BEGIN, 12'd4095, 12'd4095, 1'b0, 8'h00, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h00, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h80, 1'b0}, 1'b1,
          '{24'd6560190, 16'h8000, 8'd1, 1'b1, 1'b0}},
        // longest run at the origin
        '{'{ACT_BEGIN, 12'd0,    12'd0,    1'b1, 8'h00, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'hFF, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h34, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h12, 1'b1}, 1'b1,
          '{24'd0, 16'h1234, 8'd128, 1'b0, 1'b1}},
        // literal section of two pixels
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h01, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h11, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h22, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h33, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h44, 1'b1}, 1'b0, NO_WRITE},
        // last on a header, then last on a run low byte
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h00, 1'b1}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h85, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h01, 1'b1}, 1'b0, NO_WRITE},
        // begin in the middle of a run abandons it, then begin after begin
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h80, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'hAA, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_BEGIN, 12'd100,  12'd3,    1'b1, 8'hFF, 1'b1}, 1'b0, NO_WRITE},
        '{'{ACT_BEGIN, 12'd5,    12'd1,    1'b0, 8'h00, 1'b0}, 1'b0, NO_WRITE},
        // raw low byte dropped by a fresh begin
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h3C, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_BEGIN, 12'd5,    12'd1,    1'b0, 8'h00, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h01, 1'b0}, 1'b0, NO_WRITE},
        '{'{ACT_DATA,  12'd0,    12'd0,    1'b0, 8'h02, 1'b1}, 1'b0, NO_WRITE}
    };

    // ------------------------------------------------------------------
    // Sender side. Everything is driven at the rising edge with NBAs and
    // sampled at the edge, so DUT outputs are read before they update.
    // ------------------------------------------------------------------

    // Presents one request and holds it until accepted, then records the
    // write it should cause (typed or predicted).
    task automatic offer(input req_t r, input logic typed, input pix_write_t want);
        pix_write_t w;
        bit         produced;
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= r.act;
        pos_x     <= r.x;
        pos_y     <= r.y;
        rle_mode  <= r.mode;
        data_byte <= r.data;
        last_byte <= r.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        produced = decode_request(r, w);
        if (typed)
            pending_writes.push_back(want);
        else if (produced)
            pending_writes.push_back(w);
    endtask

    // Idle the sender and let every outstanding write come out; begins and
    // header bytes yield nothing, so allow the pipeline to empty as well.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Both registers, back to back, only while the block is idle
    task automatic set_config(input logic [LINE_BITS-1:0] line, input logic [FRAME_BITS-1:0] frame);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LINE_BYTES;
        cfg_data  <= CFG_DATA_BITS'(line);
        @(posedge clk);
        pitch_bytes = line;
        cfg_index <= CFG_FRAME_BYTES;
        cfg_data  <= frame;
        @(posedge clk);
        fb_bytes = frame;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic req_t data_req(input logic [BYTE_BITS-1:0] b, input logic last);
        req_t r;
        r.act  = ACT_DATA;
        r.x    = POS_BITS'($urandom_range(4095, 0));   // ignored on payload, toggled anyway
        r.y    = POS_BITS'($urandom_range(4095, 0));
        r.mode = 1'($urandom_range(1, 0));
        r.data = b;
        r.last = last;
        return r;
    endfunction

    // One random blit: mostly well formed, some cut short, some stray bytes
    task automatic random_blit(output int n);
        req_t q[$];
        req_t r;
        int   roll;
        int   npix;
        int   cnt;
        int   cut;
        logic coded;
        roll  = $urandom_range(99, 0);
        coded = 1'($urandom_range(1, 0));
        if (roll >= 92)
        begin
            // stray payload, carried on from wherever the parser stands
            repeat ($urandom_range(6, 1))
                q.push_back(data_req(8'($urandom), 1'($urandom_range(3, 0) == 0)));
        end
        else
        begin
            r.act  = ACT_BEGIN;
            r.mode = coded;
            r.data = 8'($urandom);
            r.last = 1'($urandom_range(1, 0));
            if ($urandom_range(4, 0) < 3)
            begin
                r.x = POS_BITS'($urandom_range(799, 0));
                r.y = POS_BITS'($urandom_range(479, 0));
            end
            else
            begin
                r.x = POS_BITS'($urandom_range(4095, 0));
                r.y = POS_BITS'($urandom_range(4095, 0));
            end
            q.push_back(r);
            if (!coded)
            begin
                npix = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
                repeat (2 * npix)
                    q.push_back(data_req(8'($urandom), 1'b0));
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                begin
                    cnt = $urandom_range(127, 0);
                    if ($urandom_range(1, 0) == 1)
                    begin
                        // repeated pixel
                        q.push_back(data_req(8'h80 | 8'(cnt), 1'b0));
                        q.push_back(data_req(8'($urandom), 1'b0));
                        q.push_back(data_req(8'($urandom), 1'b0));
                    end
                    else
                    begin
                        // literal pixels, usually few, now and then a long section
                        if ($urandom_range(24, 0) != 0)
                            cnt = $urandom_range(3, 0);
                        q.push_back(data_req(8'(cnt), 1'b0));
                        repeat (2 * (cnt + 1))
                            q.push_back(data_req(8'($urandom), 1'b0));
                    end
                end
            end
            q[q.size() - 1].last = 1'b1;
            if (roll >= 84)
            begin
                // broken blit: cut short, closed early or left open
                cut = $urandom_range(q.size() - 1, 1);
                while (q.size() > cut + 1)
                    void'(q.pop_back());
                q[cut].last = 1'($urandom_range(1, 0));
            end
        end
        foreach (q[i])
            offer(q[i], 1'b0, NO_WRITE);
        n = q.size();
    endtask

    task automatic run_phase(input logic [LINE_BITS-1:0] line, input logic [FRAME_BITS-1:0] frame,
                             input int idle, input int stall, input bit squeeze);
        int sent;
        int n;
        settle();
        set_config(line, frame);
        idle_pct  = idle;
        stall_pct = stall;
        if (squeeze)
            hold_tog <= ~hold_tog;    // receiver holds off while requests keep coming
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            random_blit(n);
            sent += n;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset register values
        for (int i = 0; i < DIR_ROWS; i++)
            offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        // random part: reset values, both extremes, random, then the squeeze
        run_phase(LINE_BYTES_RESET, FRAME_BYTES_RESET, 0, 0, 1'b0);
        run_phase(14'd0, 24'd0, 70, 0, 1'b0);
        run_phase(14'd16383, 24'hFFFFFF, 0, 70, 1'b0);
        run_phase(LINE_BITS'($urandom_range(16383, 0)), FRAME_BITS'($urandom_range(16777215, 0)),
                  7, 7, 1'b0);
        run_phase(14'd320, 24'd153600, 0, 0, 1'b1);
        settle();

        if (fault_count == 0 && pending_writes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, or a long hold-off counted here
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_tog != hold_seen)
        begin
            hold_seen <= hold_tog;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
    end

    // Every accepted write is compared with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_writes.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected write: addr %h pix %h cnt %0d oor %b eob %b",
                             write_addr, pixel_value, repeat_count, out_of_range, end_of_blit);
            end
            else
            begin
                oldest_write = pending_writes.pop_front();
                if (write_addr !== oldest_write.addr || pixel_value !== oldest_write.pix ||
                    repeat_count !== oldest_write.cnt || out_of_range !== oldest_write.oor ||
                    end_of_blit !== oldest_write.eob)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("write mismatch: want addr %h pix %h cnt %0d oor %b eob %b,",
                                 oldest_write.addr, oldest_write.pix, oldest_write.cnt,
                                 oldest_write.oor, oldest_write.eob,
                                 " got addr %h pix %h cnt %0d oor %b eob %b",
                                 write_addr, pixel_value, repeat_count, out_of_range,
                                 end_of_blit);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
